FILE: rtl/sorted_priority_task_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority task queue assertion macros
// Concurrent assertion helpers shared by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_TASK_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_TASK_QUEUE_MACROS_SVH

`ifndef SYNTH
`define SPQ_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("queue assertion failed");
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("queue assertion failed");
`else
`define SPQ_ASSERT(label, prop)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority task queue package
// Sizes, mode codes and the word and slot types of the queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY = 64;
   localparam int OCC_W    = $clog2(CAPACITY + 1);
   localparam int FILL_W   = 7;
   localparam int DATA_W   = 64;
   localparam int PRIO_W   = 8;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [DATA_W-1:0]        handler;
      logic [DATA_W-1:0]        argument;
      logic signed [PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic                     found;
      logic [DATA_W-1:0]        out_handler;
      logic [DATA_W-1:0]        out_argument;
      logic signed [PRIO_W-1:0] out_priority;
      logic [FILL_W-1:0]        fill_level;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic signed [PRIO_W-1:0] priority_val;
      logic [DATA_W-1:0]        handler;
      logic [DATA_W-1:0]        argument;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } cmd_type;

endpackage

FILE: rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority task queue cell
// One slot of the sorted shift register: compares the incoming priority and
// keeps its entry, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic               clock,
   input  logic               reset,
   input  spq_pkg::cmd_type   cmd,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_place,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               place
);

   logic                          valid_ff;
   logic                          valid_in;
   logic signed [spq_pkg::PRIO_W-1:0] prio_ff;
   logic signed [spq_pkg::PRIO_W-1:0] prio_in;
   logic [spq_pkg::DATA_W-1:0]    handler_ff;
   logic [spq_pkg::DATA_W-1:0]    handler_in;
   logic [spq_pkg::DATA_W-1:0]    argument_ff;
   logic [spq_pkg::DATA_W-1:0]    argument_in;

   // The new word belongs at or before this slot when the slot is empty or
   // holds a strictly larger priority.
   assign place = !valid_ff || (prio_ff > cmd.entry.priority_val);

   always_comb begin
      valid_in    = valid_ff;
      prio_in     = prio_ff;
      handler_in  = handler_ff;
      argument_in = argument_ff;
      if (cmd.insert && place) begin
         if (left_place) begin
            valid_in    = left_entry.valid;
            prio_in     = left_entry.priority_val;
            handler_in  = left_entry.handler;
            argument_in = left_entry.argument;
         end else begin
            valid_in    = cmd.entry.valid;
            prio_in     = cmd.entry.priority_val;
            handler_in  = cmd.entry.handler;
            argument_in = cmd.entry.argument;
         end
      end else if (cmd.pop) begin
         valid_in    = right_entry.valid;
         prio_in     = right_entry.priority_val;
         handler_in  = right_entry.handler;
         argument_in = right_entry.argument;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff     <= prio_in;
      handler_ff  <= handler_in;
      argument_ff <= argument_in;
   end

   assign entry.valid        = valid_ff;
   assign entry.priority_val = prio_ff;
   assign entry.handler      = handler_ff;
   assign entry.argument     = argument_ff;

endmodule

FILE: rtl/sorted_priority_task_queue.sv
`timescale 1ns / 1ps
// Sorted priority task queue. Holds up to 64 task entries in a row of slot
// cells kept in ascending signed priority order; equal priorities leave in
// arrival order. Every cell compares its priority against an incoming word in
// the same cycle, so an insert or a pop is taken every clock cycle unless the
// request side stalls; its response reaches the output register in the cycle
// after acceptance. The request side stalls only while that output register
// holds an untaken response. An insert into a full queue is dropped with
// accepted low; a pop of an empty queue returns found low and zero data.
// ----------------------------------------------------------------------------
// Sorted priority task queue top level
// Request handshake, occupancy count, cell chain and response register.
// ----------------------------------------------------------------------------
`include "sorted_priority_task_queue_macros.svh"

module sorted_priority_task_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   spq_pkg::cmd_type   cmd;
   spq_pkg::entry_type cell_entry [spq_pkg::CAPACITY];
   logic [spq_pkg::CAPACITY-1:0] cell_place;
   logic [spq_pkg::CAPACITY-1:0] cell_valid;

   logic [spq_pkg::OCC_W-1:0] occ_ff;
   logic [spq_pkg::OCC_W-1:0] occ_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   spq_pkg::rsp_type          rsp_data_ff;
   spq_pkg::rsp_type          rsp_data_in;

   logic fire;
   logic is_insert;
   logic is_pop;
   logic full;
   logic head_valid;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign fire       = req_valid && req_ready;
   assign is_insert  = fire && (req_data.mode == spq_pkg::MODE_INSERT);
   assign is_pop     = fire && (req_data.mode == spq_pkg::MODE_POP);
   assign full       = cell_entry[spq_pkg::CAPACITY-1].valid;
   assign head_valid = cell_entry[0].valid;

   assign cmd.insert             = is_insert && !full;
   assign cmd.pop                = is_pop && head_valid;
   assign cmd.entry.valid        = 1'b1;
   assign cmd.entry.priority_val = req_data.priority_req;
   assign cmd.entry.handler      = req_data.handler;
   assign cmd.entry.argument     = req_data.argument;

   for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_place;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_place = 1'b0;
      end else begin : g_inner_left
         assign left_entry = cell_entry[i-1];
         assign left_place = cell_place[i-1];
      end

      if (i == spq_pkg::CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_place  (left_place),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .place       (cell_place[i])
      );

      assign cell_valid[i] = cell_entry[i].valid;
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.insert) begin
         occ_in = occ_ff + spq_pkg::OCC_W'(1);
      end else if (cmd.pop) begin
         occ_in = occ_ff - spq_pkg::OCC_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.accepted     = cmd.insert;
         rsp_data_in.found        = cmd.pop;
         rsp_data_in.fill_level   = spq_pkg::FILL_W'(occ_in);
         if (cmd.pop) begin
            rsp_data_in.out_handler  = cell_entry[0].handler;
            rsp_data_in.out_argument = cell_entry[0].argument;
            rsp_data_in.out_priority = cell_entry[0].priority_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SPQ_ASSERT(a_occ_matches_cells, $countones(cell_valid) == int'(occ_ff))
   `SPQ_ASSERT(a_head_valid_iff_nonempty, head_valid == (occ_ff != '0))
   `SPQ_ASSERT_NEXT(a_pop_decrements, cmd.pop, occ_ff == $past(occ_ff) - spq_pkg::OCC_W'(1))
   `SPQ_ASSERT_NEXT(a_full_insert_dropped, is_insert && full, $stable(occ_ff) && !rsp_data.accepted)

endmodule

FILE: sim/tb_sorted_priority_task_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority task queue testbench
// Sends insert and pop words with random idling on both channels and keeps a
// sorted copy of the queue to predict every response. Each response is
// compared field by field, in arrival order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_priority_task_queue;

   class queue_scoreboard;
      spq_pkg::entry_type entries[$];
      spq_pkg::rsp_type   pending_rsp[$];
      int                 errors;
      int                 checked;
      int                 inserts;
      int                 drops;
      int                 pops;
      int                 empty_pops;
      int                 peak_fill;

      task report(string what);
         errors++;
         if (errors <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      function void note_request(spq_pkg::req_type w);
         spq_pkg::rsp_type   r;
         spq_pkg::entry_type e;
         int                 pos;
         r = '0;
         if (w.mode == spq_pkg::MODE_INSERT) begin
            inserts++;
            if (entries.size() < spq_pkg::CAPACITY) begin
               pos = 0;
               while (pos < entries.size() &&
                      $signed(entries[pos].priority_val) <= $signed(w.priority_req))
                  pos++;
               e.valid        = 1'b1;
               e.priority_val = w.priority_req;
               e.handler      = w.handler;
               e.argument     = w.argument;
               entries.insert(pos, e);
               r.accepted = 1'b1;
               if (entries.size() > peak_fill) peak_fill = entries.size();
            end else begin
               drops++;
            end
         end else begin
            pops++;
            if (entries.size() > 0) begin
               e = entries.pop_front();
               r.found        = 1'b1;
               r.out_handler  = e.handler;
               r.out_argument = e.argument;
               r.out_priority = e.priority_val;
            end else begin
               empty_pops++;
            end
         end
         r.fill_level = spq_pkg::FILL_W'(entries.size());
         pending_rsp.push_back(r);
      endfunction

      task check_response(spq_pkg::rsp_type got);
         spq_pkg::rsp_type want;
         if (pending_rsp.size() == 0) begin
            report($sformatf("response word with nothing outstanding: %h", got));
         end else begin
            want = pending_rsp.pop_front();
            checked++;
            if (got.accepted !== want.accepted)
               report($sformatf("accepted %b, predicted %b", got.accepted, want.accepted));
            if (got.found !== want.found)
               report($sformatf("found %b, predicted %b", got.found, want.found));
            if (got.out_handler !== want.out_handler)
               report($sformatf("out_handler %h, predicted %h",
                                got.out_handler, want.out_handler));
            if (got.out_argument !== want.out_argument)
               report($sformatf("out_argument %h, predicted %h",
                                got.out_argument, want.out_argument));
            if (got.out_priority !== want.out_priority)
               report($sformatf("out_priority %0d, predicted %0d",
                                $signed(got.out_priority), $signed(want.out_priority)));
            if (got.fill_level !== want.fill_level)
               report($sformatf("fill_level %0d, predicted %0d",
                                got.fill_level, want.fill_level));
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   spq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   spq_pkg::rsp_type rsp_data;

   queue_scoreboard sb = new();

   int tx_idle_pct = 30;
   int rx_idle_pct = 67;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int insert_bias[4] = '{95, 50, 5, 50};

   sorted_priority_task_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic spq_pkg::req_type make_word(logic mode,
                                                  logic [spq_pkg::DATA_W-1:0] handler,
                                                  logic [spq_pkg::DATA_W-1:0] argument,
                                                  logic [spq_pkg::PRIO_W-1:0] prio);
      spq_pkg::req_type w;
      w.mode         = mode;
      w.handler      = handler;
      w.argument     = argument;
      w.priority_req = prio;
      return w;
   endfunction

   function automatic spq_pkg::req_type random_word(int insert_pct);
      logic [spq_pkg::PRIO_W-1:0] prio;
      logic                       mode;
      case ($urandom_range(3))
         0: prio = spq_pkg::PRIO_W'($urandom_range(4)) - spq_pkg::PRIO_W'(2);
         1: begin
            case ($urandom_range(3))
               0: prio = 8'h80;
               1: prio = 8'h7f;
               2: prio = 8'h00;
               default: prio = 8'hff;
            endcase
         end
         default: prio = spq_pkg::PRIO_W'($urandom_range(255));
      endcase
      mode = ($urandom_range(99) < insert_pct) ? spq_pkg::MODE_INSERT : spq_pkg::MODE_POP;
      return make_word(mode, {$urandom(), $urandom()}, {$urandom(), $urandom()}, prio);
   endfunction

   task automatic send_word(spq_pkg::req_type w);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int guard;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words cover an empty pop, extreme priorities and data, ties
      // that must leave in arrival order, and draining back to empty.
      send_word(make_word(spq_pkg::MODE_POP, '0, '0, 8'h00));
      send_word(make_word(spq_pkg::MODE_INSERT, '1, '0, 8'h7f));
      send_word(make_word(spq_pkg::MODE_INSERT, '0, '1, 8'h80));
      send_word(make_word(spq_pkg::MODE_INSERT, 64'h1, 64'h11, 8'h00));
      send_word(make_word(spq_pkg::MODE_INSERT, 64'h2, 64'h22, 8'hff));
      send_word(make_word(spq_pkg::MODE_INSERT, 64'h3, 64'h33, 8'h00));
      send_word(make_word(spq_pkg::MODE_INSERT, 64'h4, 64'h44, 8'h00));
      send_word(make_word(spq_pkg::MODE_INSERT, 64'h5, 64'h55, 8'h7f));
      send_word(make_word(spq_pkg::MODE_INSERT, 64'h6, 64'h66, 8'h80));
      repeat (9) send_word(make_word(spq_pkg::MODE_POP, '1, '1, 8'hff));
      send_word(make_word(spq_pkg::MODE_INSERT, 64'hA5A5_5A5A_F00F_0FF0,
                          64'h0123_4567_89AB_CDEF, 8'h01));
      send_word(make_word(spq_pkg::MODE_POP, '0, '0, 8'h00));

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 67 : 0;
         rx_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 30 : 0;
         if (ph == 1) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (sb.pending_rsp.size() != 0);
         end
         for (int n = 0; n < 633; n++) begin
            if (ph == 0 && n == 200) hold_request = 1'b1;
            send_word(random_word(insert_bias[((ph * 633 + n) / 80) % 4]));
         end
      end

      req_valid <= 1'b0;
      guard = 0;
      while (sb.pending_rsp.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (sb.pending_rsp.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending_rsp.size()));

      $display("Covered %0d inserts (%0d dropped when full) and %0d pops (%0d on empty).",
               sb.inserts, sb.drops, sb.pops, sb.empty_pops);
      $display("Peak fill %0d, %0d responses checked, %0d mismatches.",
               sb.peak_fill, sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_task_queue.sv
sim/tb_sorted_priority_task_queue.sv
